// ===== rtl/vitdp_pkg.sv =====
// Package with constants, types and helpers of the punctured Viterbi decoder.
package vitdp_pkg;
	localparam int ConstraintLen = 5;
	localparam int NumSt = 1 << (ConstraintLen - 1);
	localparam int StW = ConstraintLen - 1;
	localparam int MaxSteps = 256;
	localparam int StepW = $clog2(MaxSteps);
	localparam int CntW = $clog2(MaxSteps + 1);
	localparam int GenW = 5;
	localparam int MetricW = 8;
	localparam logic [MetricW-1:0] MetricMax = 8'd255;
	localparam logic [GenW-1:0] GenFirstReset = 5'd19;
	localparam logic [GenW-1:0] GenSecondReset = 5'd29;
	localparam logic [0:0] RegGenFirst = 1'b0;
	localparam logic [0:0] RegGenSecond = 1'b1;
	localparam int WordW = 32;
	localparam int ResultLimit = 8;
	localparam logic [StW:0] MinLast = (StW + 1)'(NumSt + 1);
	localparam logic [StW:0] ClearLast = (StW + 1)'(NumSt - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACS,
		ST_WB,
		ST_MIN,
		ST_TB,
		ST_EMIT,
		ST_CLEAR
	} state_t;

	function automatic logic parity5(input logic [GenW-1:0] v);
		return ^v;
	endfunction
endpackage

// ===== rtl/vitdp_metric_ram.sv =====
// Path metric memory: one write port and one registered read port.
module vitdp_metric_ram
	import vitdp_pkg::*;
(
	input  logic               clk,
	input  logic               we,
	input  logic [StW-1:0]     waddr,
	input  logic [MetricW:0]   wdata,
	input  logic [StW-1:0]     raddr,
	output logic [MetricW:0]   rdata
);
	logic [MetricW:0] mem [NumSt];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/vitdp_surv_ram.sv =====
// Survivor memory: one row of decision bits per trellis step.
module vitdp_surv_ram
	import vitdp_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [StepW-1:0]  waddr,
	input  logic [NumSt-1:0]  wdata,
	input  logic [StepW-1:0]  raddr,
	output logic [NumSt-1:0]  rdata
);
	logic [NumSt-1:0] mem [MaxSteps];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/viterbi_decoder_punctured_unit.sv =====
// Top level of the punctured hard-decision Viterbi decoder.
// Usage:
// s_axis carries one received bit pair per transaction; tdata holds
// sym_first, sym_second, erase_first, erase_second, and tlast marks the
// end of the frame. After a pair is accepted, no new pair is taken until
// its trellis step is done: each of the sixteen states needs two reads of the
// path metric memory (valid bit stored beside each metric, two ping-pong
// banks), and the WB state then writes the last state and the survivor row.
// A pair that arrives with the survivor memory full is dropped.
// On tlast the reachable minimum is searched, traceback walks the survivor
// memory one step per cycle, and the decoded words leave on m_axis one per
// transaction, tlast on the final word.
// If m_axis stalls, the word is held; no new input is taken until the frame
// is delivered. After that the metric banks are cleared. The same clearing
// pass runs after reset before input is taken.
// The cfg channel writes gen_first (index 0) or gen_second (index 1).
module viterbi_decoder_punctured_unit
	import vitdp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // sym_first, sym_second, erase_first, erase_second
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // decoded_word, bit_count
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [4:0]  cfg_data
);
	state_t state_q, state_d;
	logic [GenW-1:0] gen_first_q, gen_second_q;
	logic [3:0] sym_q;
	logic fe_q;
	logic bank_q;
	logic [StW:0] cnt_q;
	logic [NumSt-1:0] choice_q;
	logic [CntW-1:0] steps_q, tb_q, rem_q, tb_m1;
	logic [StW-1:0] best_q, s_q;
	logic [MetricW-1:0] bestval_q;
	logic found_q;
	logic [WordW*ResultLimit-1:0] words_q;
	logic [MetricW:0] a0, a1, cur_rd;
	logic [MetricW:0] p_reg_q;
	logic [NumSt-1:0] srow, srow_wd;
	logic [StW-1:0] i_s1, min_idx_s1;
	logic act_s1, min_v_s1, tbv_s1;
	logic we0, we1, sw_e;
	logic [StW-1:0] wa, ra;
	logic [MetricW:0] wd;
	logic [StepW-1:0] sra;
	logic [StW-1:0] acs_i, pred;
	logic acs_ph;
	logic [MetricW:0] m0, m1, res;
	logic sel;
	logic s_acc, m_acc;

	// Two banks: bank_q selects the one that holds the current metrics.
	vitdp_metric_ram u_b0 (.clk, .we(we0), .waddr(wa), .wdata(wd), .raddr(ra), .rdata(a0));
	vitdp_metric_ram u_b1 (.clk, .we(we1), .waddr(wa), .wdata(wd), .raddr(ra), .rdata(a1));

	vitdp_surv_ram u_sv (.clk, .we(sw_e), .waddr(steps_q[StepW-1:0]), .wdata(srow_wd),
		.raddr(sra), .rdata(srow));

	// ACS sub-cycle: cnt_q = {state[3:0], phase}. Phase 0 reads pred j=0,
	// phase 1 reads pred j=1; the result is written on the following cycle.
	assign acs_i = cnt_q[StW:1];
	assign acs_ph = cnt_q[0];
	assign pred = {acs_i[StW-2:0], acs_ph};
	assign cur_rd = bank_q ? a1 : a0;

	function automatic logic [MetricW:0] branch(input logic [MetricW:0] pm,
		input logic [StW-1:0] i, input logic j, input logic [3:0] sy,
		input logic [GenW-1:0] g1, input logic [GenW-1:0] g2);
		logic [GenW-1:0] r;
		logic c1, c2;
		logic [MetricW+1:0] m;
		r = {i, j};
		c1 = sy[2] ? 1'b0 : (parity5(r & g1) ^ sy[0]);
		c2 = sy[3] ? 1'b0 : (parity5(r & g2) ^ sy[1]);
		m = {2'b00, pm[MetricW-1:0]} + {{(MetricW+1){1'b0}}, c1} +
			{{(MetricW+1){1'b0}}, c2};
		if (!pm[MetricW]) return '0;
		if (m > {2'b00, MetricMax}) return {1'b1, MetricMax};
		return {1'b1, m[MetricW-1:0]};
	endfunction

	// p_reg_q holds the j=0 predecessor, cur_rd the j=1 predecessor.
	always_comb begin
		m0 = branch(p_reg_q, i_s1, 1'b0, sym_q, gen_first_q, gen_second_q);
		m1 = branch(cur_rd, i_s1, 1'b1, sym_q, gen_first_q, gen_second_q);
		sel = 1'b0;
		res = '0;
		if (m1[MetricW] && (!m0[MetricW] || m1[MetricW-1:0] <= m0[MetricW-1:0])) begin
			sel = 1'b1;
			res = m1;
		end else if (m0[MetricW]) begin
			res = m0;
		end
	end

	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign m_acc = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign tb_m1 = tb_q - CntW'(1);
	assign srow_wd = {sel, choice_q[NumSt-2:0]};

	always_comb begin
		we0 = 1'b0;
		we1 = 1'b0;
		wa = i_s1;
		wd = res;
		ra = pred;
		sw_e = (state_q == ST_WB);
		sra = tb_m1[StepW-1:0];
		if (act_s1) begin
			we0 = bank_q;
			we1 = !bank_q;
		end
		if (state_q == ST_MIN) ra = cnt_q[StW-1:0];
		if (state_q == ST_CLEAR) begin
			we0 = 1'b1;
			we1 = 1'b1;
			wa = cnt_q[StW-1:0];
			wd = (cnt_q[StW-1:0] == '0) ? {1'b1, {MetricW{1'b0}}} : '0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_acc) begin
				if (steps_q < CntW'(MaxSteps)) state_d = ST_ACS;
				else if (s_axis_tlast) state_d = ST_MIN;
			end
			ST_ACS: if (cnt_q == '1) state_d = ST_WB;
			ST_WB: state_d = fe_q ? ST_MIN : ST_IDLE;
			ST_MIN: if (cnt_q == MinLast) state_d = ST_TB;
			ST_TB: if (tb_q == '0) state_d = ST_EMIT;
			ST_EMIT: if (m_acc && m_axis_tlast) state_d = ST_CLEAR;
			ST_CLEAR: if (cnt_q == ClearLast) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			gen_first_q <= GenFirstReset;
			gen_second_q <= GenSecondReset;
			cnt_q <= '0;
			bank_q <= 1'b0;
			steps_q <= '0;
			tb_q <= '0;
			rem_q <= '0;
			act_s1 <= 1'b0;
			min_v_s1 <= 1'b0;
			tbv_s1 <= 1'b0;
			fe_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == RegGenFirst) gen_first_q <= cfg_data;
				if (cfg_index == RegGenSecond) gen_second_q <= cfg_data;
			end
			act_s1 <= (state_q == ST_ACS) && acs_ph;
			min_v_s1 <= (state_q == ST_MIN) && !cnt_q[StW];
			tbv_s1 <= (state_q == ST_TB) && (tb_q != '0);
			if (state_d != state_q) cnt_q <= '0;
			else cnt_q <= cnt_q + {{StW{1'b0}}, 1'b1};
			case (state_q)
				ST_IDLE: if (s_acc) fe_q <= s_axis_tlast;
				ST_WB: begin
					steps_q <= steps_q + CntW'(1);
					bank_q <= !bank_q;
				end
				ST_MIN: if (cnt_q == MinLast) begin
					tb_q <= steps_q;
					rem_q <= steps_q;
				end
				ST_TB: if (tb_q != '0) tb_q <= tb_m1;
				ST_EMIT: if (m_acc) rem_q <= rem_q - CntW'(WordW);
				ST_CLEAR: begin
					steps_q <= '0;
					bank_q <= 1'b0;
					fe_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		i_s1 <= acs_i;
		p_reg_q <= cur_rd;
		min_idx_s1 <= cnt_q[StW-1:0];
		if (s_acc) sym_q <= s_axis_tdata[3:0];
		if (act_s1) choice_q[i_s1] <= sel;
		if (min_v_s1 && cur_rd[MetricW] &&
			(!found_q || cur_rd[MetricW-1:0] <= bestval_q)) begin
			found_q <= 1'b1;
			bestval_q <= cur_rd[MetricW-1:0];
			best_q <= min_idx_s1;
		end else if (state_q == ST_MIN && cnt_q == '0) begin
			found_q <= 1'b0;
			best_q <= '0;
		end
		// Traceback shifts each decoded bit in at the top, so the first bit of
		// the frame ends up in the MSB of the top word.
		if (state_q == ST_MIN && cnt_q == MinLast) begin
			s_q <= best_q;
			words_q <= '0;
		end else if (tbv_s1) begin
			s_q <= {s_q[StW-2:0], srow[s_q]};
			words_q <= {s_q[StW-1], words_q[WordW*ResultLimit-1:1]};
		end else if (m_acc) begin
			words_q <= {words_q[WordW*ResultLimit-WordW-1:0], {WordW{1'b0}}};
		end
	end

	assign m_axis_tvalid = (state_q == ST_EMIT);
	assign m_axis_tdata = {2'b00, (rem_q > CntW'(WordW)) ? 6'd32 : rem_q[5:0],
		words_q[WordW*ResultLimit-1 -: WordW]};
	assign m_axis_tlast = (rem_q <= CntW'(WordW));
endmodule
